// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the framer core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SPCF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SPCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/spcf_pkg.sv -----
`default_nettype none

package spcf_pkg;

	// Default sizes of the protected memory.
	localparam int unsigned DEF_PAGE_BYTES   = 32;
	localparam int unsigned DEF_MEMORY_BYTES = 65536;

	// CRC-16/IBM-3740 constants.
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	// Item operation codes.
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_DATA  = 2'd1;
	localparam logic [1:0] OP_CRC   = 2'd2;

	// Result status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_MISALIGNED = 3'd1;
	localparam logic [2:0] ST_BEYOND     = 3'd2;
	localparam logic [2:0] ST_MISMATCH   = 3'd3;
	localparam logic [2:0] ST_SEQUENCE   = 3'd4;

	// Framing phase of the current page.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA,
		PH_DONE,
		PH_CRCLO
	} phase_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] address;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] crc_value;
		logic        page_done;
	} rsp_t;

	// Contents of the input register: the item plus work done ahead of the core.
	typedef struct packed {
		req_t        item;
		logic [15:0] seed;      // CRC after the address high byte
		logic [15:0] quot;      // address divided by the page size
	} stage_t;

	// One byte through the CRC, MSB first, unrolled over eight bit steps.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/secure_page_crc16_framer.sv -----
`default_nettype none

// Secure page CRC framer: guards one page of a byte memory with CRC-16/IBM-3740
// (poly 0x1021, init 0xFFFF, MSB first, no final XOR), seeded with the page
// address high byte then low byte. Every request transaction (begin, data byte,
// received CRC byte) gives exactly one response transaction, through the input
// register and then the result register, and a new request is accepted every
// cycle while the response side keeps up. The rate is set by the core's update of
// the running CRC, byte count and phase, which each item reads and writes in the
// cycle it leaves the input register. The input register divides the address by
// the page size with a reciprocal multiply and folds the address high byte into
// the CRC ahead of time; the core checks alignment and the memory bound and runs
// the framing. After the last page byte the response carries the CRC to send; on a
// read the second received CRC byte is compared and a mismatch is flagged.
module secure_page_crc16_framer #(
	parameter int unsigned PAGE_BYTES   = spcf_pkg::DEF_PAGE_BYTES,
	parameter int unsigned MEMORY_BYTES = spcf_pkg::DEF_MEMORY_BYTES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire spcf_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output spcf_pkg::rsp_t       rsp
);
	import spcf_pkg::*;

	logic   valid_s1;
	stage_t stage_s1;
	logic   advance;

	// Input register with the address pre-processing.
	spcf_in_stage #(
		.PAGE_BYTES(PAGE_BYTES)
	) u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1)
	);

	// Framing state, CRC update and result register.
	spcf_core #(
		.PAGE_BYTES  (PAGE_BYTES),
		.MEMORY_BYTES(MEMORY_BYTES)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.stage_s1 (stage_s1),
		.advance  (advance),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ----- rtl/core/spcf_in_stage.sv -----
`default_nettype none

module spcf_in_stage #(
	parameter int unsigned PAGE_BYTES = spcf_pkg::DEF_PAGE_BYTES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire spcf_pkg::req_t  req,
	input  wire logic            advance,
	output logic                 valid_s1,
	output spcf_pkg::stage_t     stage_s1
);
	import spcf_pkg::*;

	// Reciprocal of the page size, exact for every 16-bit address.
	localparam int unsigned LogP = $clog2(PAGE_BYTES);
	localparam int unsigned Shift = 16 + LogP;
	localparam longint unsigned RecipL =
		((64'd1 << Shift) + longint'(PAGE_BYTES) - 64'd1) / longint'(PAGE_BYTES);
	localparam logic [17:0] Recip = RecipL[17:0];

	logic [39:0] prod;
	logic        load;

	// The register takes a new transaction when empty or when its item moves on.
	assign req_stall = valid_s1 && !advance;
	assign load      = req_valid && !req_stall;
	assign prod      = 40'(req.address) * 40'(Recip);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= req_valid;
		end
	end

	// Payload, with the first address byte folded into the CRC already.
	always_ff @(posedge clk) begin
		if (load) begin
			stage_s1.item <= req;
			stage_s1.seed <= crc_byte(CRC_INIT, req.address[15:8]);
			stage_s1.quot <= prod[Shift +: 16];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/spcf_core.sv -----
`default_nettype none

module spcf_core #(
	parameter int unsigned PAGE_BYTES   = spcf_pkg::DEF_PAGE_BYTES,
	parameter int unsigned MEMORY_BYTES = spcf_pkg::DEF_MEMORY_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire spcf_pkg::stage_t  stage_s1,
	output logic                   advance,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output spcf_pkg::rsp_t         rsp
);
	import spcf_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned CntW = $clog2(PAGE_BYTES + 1);

	phase_t            phase_q, phase_n;
	logic [15:0]       crc_q, crc_n;
	logic [CntW-1:0]   cnt_q, cnt_n;
	logic [7:0]        crc_high_q, crc_high_n;
	logic [2:0]        status;
	logic              done;
	logic [24:0]       back_prod;
	logic              misaligned;
	logic              beyond;
	req_t              item;

	assign item = stage_s1.item;

	// The result register frees up when empty or when its transaction is taken.
	assign advance = valid_s1 && (!rsp_valid || !rsp_stall);

	// Address checks: aligned exactly when the quotient times the page size gives it back.
	assign back_prod  = 25'(stage_s1.quot) * 25'(PAGE_BYTES);
	assign misaligned = back_prod != 25'(item.address);
	assign beyond     = (18'(item.address) + 18'(PAGE_BYTES)) > 18'(MEMORY_BYTES);

	// Next framing state and the result of the item in the input register.
	always_comb begin
		phase_n    = phase_q;
		crc_n      = crc_q;
		cnt_n      = cnt_q;
		crc_high_n = crc_high_q;
		status     = ST_OK;
		done       = 1'b0;
		unique case (item.op)
			OP_BEGIN: begin
				crc_n   = CRC_INIT;
				cnt_n   = '0;
				phase_n = PH_IDLE;
				if (misaligned) begin
					status = ST_MISALIGNED;
				end else if (beyond) begin
					status = ST_BEYOND;
				end else begin
					crc_n   = crc_byte(stage_s1.seed, item.address[7:0]);
					phase_n = PH_DATA;
				end
			end
			OP_DATA: begin
				if (phase_q != PH_DATA) begin
					status = ST_SEQUENCE;
				end else begin
					crc_n = crc_byte(crc_q, item.data_byte);
					cnt_n = cnt_q + CntW'(1);
					if (cnt_n == CntW'(PAGE_BYTES)) begin
						phase_n = PH_DONE;
						done    = 1'b1;
					end
				end
			end
			OP_CRC: begin
				unique case (phase_q)
					PH_DONE: begin
						crc_high_n = item.data_byte;
						phase_n    = PH_CRCLO;
					end
					PH_CRCLO: begin
						if ({crc_high_q, item.data_byte} != crc_q) begin
							status = ST_MISMATCH;
						end
						done    = 1'b1;
						phase_n = PH_IDLE;
					end
					default: begin
						status = ST_SEQUENCE;
					end
				endcase
			end
			default: begin
				status = ST_SEQUENCE;
			end
		endcase
	end

	// Framing state, committed as each transaction moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			crc_q      <= CRC_INIT;
			cnt_q      <= '0;
			crc_high_q <= '0;
		end else if (advance) begin
			phase_q    <= phase_n;
			crc_q      <= crc_n;
			cnt_q      <= cnt_n;
			crc_high_q <= crc_high_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (!rsp_valid || !rsp_stall) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.status    <= status;
			rsp.crc_value <= crc_n;
			rsp.page_done <= done;
		end
	end

	`SPCF_ASSERT(a_count_in_page, clk, arst_n, (phase_q == PH_DATA) |-> (cnt_q < CntW'(PAGE_BYTES)), "byte count ran past the page while taking data")
	`SPCF_ASSERT(a_bad_begin_clears, clk, arst_n, (advance && item.op == OP_BEGIN && (misaligned || beyond)) |=> (phase_q == PH_IDLE && crc_q == CRC_INIT), "rejected begin left framing state behind")
	`SPCF_ASSERT(a_mismatch_done, clk, arst_n, (rsp_valid && rsp.status == ST_MISMATCH) |-> rsp.page_done, "crc mismatch reported without page completion")
	`SPCF_ASSERT(a_done_status, clk, arst_n, (rsp_valid && rsp.page_done) |-> (rsp.status == ST_OK || rsp.status == ST_MISMATCH), "page completion carried an error status")
	`SPCF_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n |=> (phase_q == PH_IDLE && !rsp_valid), "framer not idle after reset")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

import spcf_pkg::*;

// Tracks the framing state of the block and holds the responses that are still due.
class page_crc_tracker;
	localparam int unsigned PAGE   = DEF_PAGE_BYTES;
	localparam int unsigned MEMORY = DEF_MEMORY_BYTES;

	logic [15:0] crc;
	int unsigned count;
	phase_t      phase;
	logic [7:0]  crc_high;
	rsp_t        expected_q[$];
	int unsigned errors;

	function new();
		crc = CRC_INIT;
		count = 0;
		phase = PH_IDLE;
		crc_high = '0;
		errors = 0;
	endfunction

	// Shifts one byte into the CRC a bit at a time, MSB first.
	static function logic [15:0] fold_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		logic        fb;
		r = c;
		for (int i = 7; i >= 0; i--) begin
			fb = r[15] ^ b[i];
			r = {r[14:0], 1'b0};
			if (fb) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	// Advances the framing state for one accepted request transaction.
	function void note_request(req_t item);
		rsp_t e;
		e.status = ST_OK;
		e.page_done = 1'b0;
		case (item.op)
			OP_BEGIN: begin
				crc = CRC_INIT;
				count = 0;
				phase = PH_IDLE;
				if ((item.address % PAGE) != 0) begin
					e.status = ST_MISALIGNED;
				end else if (32'(item.address) + PAGE > MEMORY) begin
					e.status = ST_BEYOND;
				end else begin
					crc = fold_byte(fold_byte(crc, item.address[15:8]), item.address[7:0]);
					phase = PH_DATA;
				end
			end
			OP_DATA: begin
				if (phase != PH_DATA) begin
					e.status = ST_SEQUENCE;
				end else begin
					crc = fold_byte(crc, item.data_byte);
					count++;
					if (count >= PAGE) begin
						phase = PH_DONE;
						e.page_done = 1'b1;
					end
				end
			end
			OP_CRC: begin
				if (phase == PH_DONE) begin
					crc_high = item.data_byte;
					phase = PH_CRCLO;
				end else if (phase == PH_CRCLO) begin
					if ({crc_high, item.data_byte} != crc) begin
						e.status = ST_MISMATCH;
					end
					e.page_done = 1'b1;
					phase = PH_IDLE;
				end else begin
					e.status = ST_SEQUENCE;
				end
			end
			default: begin
				e.status = ST_SEQUENCE;
			end
		endcase
		e.crc_value = crc;
		expected_q.push_back(e);
	endfunction

	// Compares one accepted response transaction with the oldest one due.
	function void check_response(rsp_t got);
		rsp_t e;
		if (expected_q.size() == 0) begin
			errors++;
			$display("%0t: response with none due: status %0d crc %h done %0d",
				$time, got.status, got.crc_value, got.page_done);
			return;
		end
		e = expected_q.pop_front();
		if (got.status !== e.status) begin
			errors++;
			$display("%0t: status expected %0d, got %0d", $time, e.status, got.status);
		end
		if (got.crc_value !== e.crc_value) begin
			errors++;
			$display("%0t: crc_value expected %h, got %h", $time, e.crc_value, got.crc_value);
		end
		if (got.page_done !== e.page_done) begin
			errors++;
			$display("%0t: page_done expected %0d, got %0d", $time, e.page_done,
				got.page_done);
		end
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction
endclass

module testbench;
	localparam int unsigned PAGE_BYTES   = DEF_PAGE_BYTES;
	localparam int unsigned MEMORY_BYTES = DEF_MEMORY_BYTES;
	localparam int unsigned ITEM_TARGET  = 1400;
	localparam int unsigned DRAIN_CYCLES = 20;

	// The op code that carries no meaning.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Ways in which a page sequence is closed.
	typedef enum int unsigned {
		READ_GOOD,
		READ_BAD,
		WRITE_ONLY,
		CUT_SHORT,
		OVERRUN,
		HALF_CRC
	} page_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	page_crc_tracker tracker = new();
	int unsigned     items_sent = 0;
	bit              sender_calm = 1'b0;

	always #5 clk = ~clk;

	secure_page_crc16_framer #(
		.PAGE_BYTES(PAGE_BYTES),
		.MEMORY_BYTES(MEMORY_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Both monitors in one block so that a request is noted before its response is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				tracker.note_request(req);
			end
			if (rsp_valid && !rsp_stall) begin
				tracker.check_response(rsp);
			end
		end
	end

	function automatic req_t item_of(logic [1:0] op, logic [15:0] address, logic [7:0] b);
		req_t r;
		r.op = op;
		r.address = address;
		r.data_byte = b;
		return r;
	endfunction

	// Mostly back to back, sometimes a short pause, rarely a long one.
	function automatic int unsigned sender_gap();
		int unsigned r;
		if (sender_calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Offers one request transaction and returns at the edge where it is taken.
	task automatic send_item(input req_t item);
		int unsigned gap;
		gap = sender_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	// Sends a begin, the page bytes (fewer when cut short) and then the chosen close of the page.
	task automatic send_page(input logic [15:0] base, input page_end_t ending);
		logic [15:0] crc;
		logic [15:0] sent_crc;
		logic [7:0]  b;
		int unsigned byte_limit;
		crc = tracker.fold_byte(tracker.fold_byte(CRC_INIT, base[15:8]), base[7:0]);
		byte_limit = (ending == CUT_SHORT) ? $urandom_range(0, PAGE_BYTES - 1) : PAGE_BYTES;
		send_item(item_of(OP_BEGIN, base, 8'($urandom)));
		for (int i = 0; i < byte_limit; i++) begin
			b = 8'($urandom);
			crc = tracker.fold_byte(crc, b);
			send_item(item_of(OP_DATA, 16'($urandom), b));
		end
		sent_crc = crc;
		case (ending)
			READ_BAD: begin
				sent_crc = crc ^ (16'h0001 << $urandom_range(0, 15));
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[15:8]));
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[7:0]));
			end
			READ_GOOD: begin
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[15:8]));
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[7:0]));
			end
			CUT_SHORT: begin
				// A CRC byte while data is still due.
				send_item(item_of(OP_CRC, 16'($urandom), 8'($urandom)));
			end
			OVERRUN: begin
				// A data byte past the end of the page leaves the state alone.
				send_item(item_of(OP_DATA, 16'($urandom), 8'($urandom)));
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[15:8]));
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[7:0]));
			end
			HALF_CRC: begin
				send_item(item_of(OP_CRC, 16'($urandom), sent_crc[15:8]));
				if ($urandom_range(0, 1) == 0) begin
					send_item(item_of(OP_DATA, 16'($urandom), 8'($urandom)));
				end
			end
			default: begin
			end
		endcase
	endtask

	function automatic page_end_t pick_ending();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 35) return READ_GOOD;
		if (r < 55) return READ_BAD;
		if (r < 75) return WRITE_ONLY;
		if (r < 85) return CUT_SHORT;
		if (r < 93) return OVERRUN;
		return HALF_CRC;
	endfunction

	// Response side stalls in bursts, with long stretches of no stall now and then.
	initial begin
		int unsigned hold;
		int unsigned free_run;
		int unsigned r;
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			hold = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 6);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat (free_run) @(posedge clk);
		end
	end

	// Main sequence: reset, directed cases, random pages and noise, drain.
	initial begin
		logic [15:0] base;
		int unsigned r;
		// A real falling edge on the reset so that the asynchronous reset takes effect.
		arst_n <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out-of-order items while idle and the meaningless op.
		send_item(item_of(OP_DATA, 16'hFFFF, 8'hFF));
		send_item(item_of(OP_CRC, 16'h0000, 8'h00));
		send_item(item_of(OP_UNUSED, 16'hFFFF, 8'hFF));
		// Address checks, with the last page of memory just inside.
		send_item(item_of(OP_BEGIN, 16'h0001, 8'h00));
		send_item(item_of(OP_BEGIN, 16'hFFFF, 8'hFF));
		send_item(item_of(OP_BEGIN, 16'h0010, 8'h00));
		send_item(item_of(OP_BEGIN, 16'hFFE0, 8'hFF));
		send_item(item_of(OP_DATA, 16'h0000, 8'h00));
		send_item(item_of(OP_DATA, 16'hFFFF, 8'hFF));
		send_item(item_of(OP_CRC, 16'h0000, 8'hA5));
		send_item(item_of(OP_UNUSED, 16'h0000, 8'h00));
		// A begin in the middle of a page abandons it.
		send_item(item_of(OP_BEGIN, 16'h0000, 8'h00));
		send_item(item_of(OP_DATA, 16'h0000, 8'h80));
		send_item(item_of(OP_DATA, 16'h0000, 8'h01));
		send_item(item_of(OP_BEGIN, 16'h8020, 8'h00));

		while (items_sent < ITEM_TARGET) begin
			sender_calm = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 75) begin
				case ($urandom_range(0, 9))
					0: base = 16'h0000;
					1: base = 16'(MEMORY_BYTES - PAGE_BYTES);
					default: base = 16'($urandom_range(0, MEMORY_BYTES / PAGE_BYTES - 1)
						* PAGE_BYTES);
				endcase
				send_page(base, pick_ending());
			end else begin
				repeat ($urandom_range(1, 6)) begin
					send_item(item_of(2'($urandom), 16'($urandom), 8'($urandom)));
				end
			end
		end
		req_valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#12_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
